FILE: rtl/uer_pkg.sv
// Package with the types and constants of the ultrasonic echo ranger.
package uer_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgTriggerTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCountLimit   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTicksPerCm   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgFarThreshold = 2'd3;

  localparam logic [7:0]  TriggerTicksRst = 8'd10;
  localparam logic [15:0] CountLimitRst   = 16'd38000;
  localparam logic [7:0]  TicksPerCmRst   = 8'd59;
  localparam logic [9:0]  FarThresholdRst = 10'd7;

  localparam logic [15:0] TicksMax = 16'hFFFF;
  localparam logic [9:0]  DistMax  = 10'd999;
  localparam logic [3:0]  DigitMax = 4'd9;

  typedef enum logic [3:0] {
    PhIdle  = 4'b0001,
    PhTrig  = 4'b0010,
    PhWait  = 4'b0100,
    PhCount = 4'b1000
  } phase_e;

  typedef struct packed {
    logic start_req;
    logic echo;
  } uer_in_t;

  typedef struct packed {
    logic       trigger;
    logic       busy_res;
    logic       done_res;
    logic [9:0] distance_cm;
    logic [3:0] digit_hundreds;
    logic [3:0] digit_tens;
    logic [3:0] digit_ones;
    logic       far_flag;
  } uer_out_t;

endpackage

FILE: rtl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: trigger control, echo counting and distance result.
//
//  Channel   Direction  Handshake                 Payload
//  in        input      in_valid_i / in_ready_o    in_data_i  (uer_in_t, one clock tick)
//  out       output     out_valid_o / out_ready_i  out_data_o (uer_out_t, one per transaction)
//  cfg       input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// Each input transaction is processed combinationally and its result is held in the output register.
// A new transaction is taken every cycle while the output register is empty or being drained.
// Distance and its decimal digits are counted while echo is high, so no divider is needed.
// Reset returns the sequencer to idle, clears the counters and loads the register defaults.
// A stall on the output side holds the result and stops input acceptance until it drains.
module ultrasonic_echo_ranger (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  uer_pkg::uer_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output uer_pkg::uer_out_t            out_data_o,
  input  logic                         cfg_we_i,
  input  logic [uer_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [uer_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import uer_pkg::*;

  logic [7:0]  trig_ticks_q;
  logic [15:0] count_limit_q;
  logic [7:0]  tpc_q;
  logic [9:0]  far_thr_q;

  phase_e      phase_q, phase_d;
  logic [7:0]  pulse_q, pulse_d;
  logic [15:0] ticks_q, ticks_d;
  logic [7:0]  rem_q, rem_d;
  logic [9:0]  run_q, run_d;
  logic [3:0]  run_h_q, run_h_d, run_t_q, run_t_d, run_o_q, run_o_d;
  logic [9:0]  dist_q, dist_d;
  logic [3:0]  dist_h_q, dist_h_d, dist_t_q, dist_t_d, dist_o_q, dist_o_d;

  logic        out_valid_q;
  uer_out_t    out_q, res;
  logic        accept;
  logic [7:0]  tt_eff, tpc_eff, rem_inc;
  logic        trig, done, tick;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign tt_eff  = (trig_ticks_q == 8'd0) ? 8'd1 : trig_ticks_q;
  assign tpc_eff = (tpc_q == 8'd0) ? 8'd1 : tpc_q;
  assign rem_inc = rem_q + 8'd1;

  always_comb begin
    phase_d  = phase_q;
    pulse_d  = pulse_q;
    ticks_d  = ticks_q;
    rem_d    = rem_q;
    run_d    = run_q;
    run_h_d  = run_h_q;
    run_t_d  = run_t_q;
    run_o_d  = run_o_q;
    dist_d   = dist_q;
    dist_h_d = dist_h_q;
    dist_t_d = dist_t_q;
    dist_o_d = dist_o_q;
    trig     = 1'b0;
    done     = 1'b0;
    tick     = 1'b0;
    case (phase_q)
      PhIdle: begin
        if (in_data_i.start_req) begin
          ticks_d = '0;
          rem_d   = '0;
          run_d   = '0;
          run_h_d = '0;
          run_t_d = '0;
          run_o_d = '0;
          pulse_d = 8'd1;
          phase_d = PhTrig;
          trig    = 1'b1;
        end
      end
      PhTrig: begin
        if (pulse_q >= tt_eff) begin
          phase_d = PhWait;
        end else begin
          pulse_d = pulse_q + 8'd1;
          trig    = 1'b1;
        end
      end
      PhWait: begin
        if (in_data_i.echo) begin
          phase_d = PhCount;
          tick    = 1'b1;
        end
      end
      PhCount: begin
        if (in_data_i.echo) begin
          tick = 1'b1;
        end else begin
          if (ticks_q < count_limit_q) begin
            dist_d   = run_q;
            dist_h_d = run_h_q;
            dist_t_d = run_t_q;
            dist_o_d = run_o_q;
          end else begin
            dist_d   = '0;
            dist_h_d = '0;
            dist_t_d = '0;
            dist_o_d = '0;
          end
          done    = 1'b1;
          phase_d = PhIdle;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    if (tick && ticks_q != TicksMax) begin
      ticks_d = ticks_q + 16'd1;
      if (rem_inc >= tpc_eff) begin
        rem_d = '0;
        if (run_q < DistMax) begin
          run_d = run_q + 10'd1;
          if (run_o_q == DigitMax) begin
            run_o_d = '0;
            if (run_t_q == DigitMax) begin
              run_t_d = '0;
              run_h_d = run_h_q + 4'd1;
            end else begin
              run_t_d = run_t_q + 4'd1;
            end
          end else begin
            run_o_d = run_o_q + 4'd1;
          end
        end
      end else begin
        rem_d = rem_inc;
      end
    end

    res.trigger        = trig;
    res.busy_res       = (phase_d != PhIdle);
    res.done_res       = done;
    res.distance_cm    = dist_d;
    res.digit_hundreds = dist_h_d;
    res.digit_tens     = dist_t_d;
    res.digit_ones     = dist_o_d;
    res.far_flag       = (dist_d > far_thr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_ticks_q  <= TriggerTicksRst;
      count_limit_q <= CountLimitRst;
      tpc_q         <= TicksPerCmRst;
      far_thr_q     <= FarThresholdRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTriggerTicks: trig_ticks_q  <= cfg_wdata_i[7:0];
        CfgCountLimit:   count_limit_q <= cfg_wdata_i;
        CfgTicksPerCm:   tpc_q         <= cfg_wdata_i[7:0];
        CfgFarThreshold: far_thr_q     <= cfg_wdata_i[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      pulse_q  <= '0;
      ticks_q  <= '0;
      rem_q    <= '0;
      run_q    <= '0;
      run_h_q  <= '0;
      run_t_q  <= '0;
      run_o_q  <= '0;
      dist_q   <= '0;
      dist_h_q <= '0;
      dist_t_q <= '0;
      dist_o_q <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      pulse_q  <= pulse_d;
      ticks_q  <= ticks_d;
      rem_q    <= rem_d;
      run_q    <= run_d;
      run_h_q  <= run_h_d;
      run_t_q  <= run_t_d;
      run_o_q  <= run_o_d;
      dist_q   <= dist_d;
      dist_h_q <= dist_h_d;
      dist_t_q <= dist_t_d;
      dist_o_q <= dist_o_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

endmodule
